/* rtl/core/bpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bpe_pkg;

   localparam int MAX_DEGREE  = 10;
   localparam int COEF_COUNT  = 66;
   localparam int COORD_WIDTH = 16;
   localparam int COEF_WIDTH  = 32;
   localparam int ACC_WIDTH   = 48;
   localparam int OUT_WIDTH   = 32;
   localparam int DEG_WIDTH   = 4;
   localparam int INDEX_WIDTH = 7;
   localparam int FRAC        = COORD_WIDTH - 1;
   localparam int MONO_WIDTH  = COORD_WIDTH + 1;
   localparam int COEF_ADDR_W = $clog2(COEF_COUNT);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // highest degree whose coefficient count still fits the store
   function automatic int eff_max_degree();
      int d;
      d = MAX_DEGREE;
      while (d > 0 && (d + 1) * (d + 2) / 2 > COEF_COUNT)
         d = d - 1;
      return d;
   endfunction

   localparam int EFF_MAX_DEGREE = eff_max_degree();

   localparam logic [CSR_ADDR_W-3:0] REG_POLY_DEGREE = '0;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic signed [MONO_WIDTH-1:0] MONO_ONE = MONO_WIDTH'(1) << FRAC;

   typedef struct packed {
      logic                          req_type;
      logic [INDEX_WIDTH-1:0]        coef_index;
      logic signed [COEF_WIDTH-1:0]  coef_value;
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] poly_value;
      logic                        saturated;
   } rsp_word_type;

   // (c * m + half) >>> FRAC, new monomial
   function automatic logic signed [MONO_WIDTH-1:0] mono_mul(
      input logic signed [COORD_WIDTH-1:0] c,
      input logic signed [MONO_WIDTH-1:0]  m);
      logic signed [COORD_WIDTH+MONO_WIDTH:0] p;
      p = c * m;
      p = p + ((COORD_WIDTH + MONO_WIDTH + 1)'(1) << (FRAC - 1));
      return p[FRAC+MONO_WIDTH-1:FRAC];
   endfunction

   // (coef * m + half) >>> FRAC, one term of the sum
   function automatic logic signed [ACC_WIDTH-1:0] term_mul(
      input logic signed [COEF_WIDTH-1:0] cf,
      input logic signed [MONO_WIDTH-1:0] m);
      logic signed [COEF_WIDTH+MONO_WIDTH:0] p;
      p = cf * m;
      p = p + ((COEF_WIDTH + MONO_WIDTH + 1)'(1) << (FRAC - 1));
      return ACC_WIDTH'(p >>> FRAC);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/bpe_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module bpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 66
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first on a clash
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/bivariate_polynomial_evaluator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Load word: taken when idle, gives no result.
// Evaluate word: one term per cycle through one multiply-accumulate pipeline, but for
// interlock bubbles; for D >= 2 (D = degree in use) one monomial-store interlock bubble
// falls at the start of row two.
// Input stalls until the result word is registered, so one evaluate word runs at a time.
// Reset (synchronous): degree 0, all coefficient valid bits cleared so the store reads zero.
module bivariate_polynomial_evaluator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire bpe_pkg::req_word_type          req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output bpe_pkg::rsp_word_type               rsp_data,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [bpe_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [bpe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bpe_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   localparam int AW = bpe_pkg::COEF_ADDR_W;
   localparam int DW = bpe_pkg::DEG_WIDTH;
   localparam int MW = bpe_pkg::MONO_WIDTH;
   localparam int CW = bpe_pkg::COEF_WIDTH;
   localparam int XW = bpe_pkg::COORD_WIDTH;
   localparam int ACW = bpe_pkg::ACC_WIDTH;
   localparam int OW = bpe_pkg::OUT_WIDTH;

   state_type state_ff, state_in;

   logic [DW-1:0] poly_degree_ff;
   logic [DW-1:0] deg_ff;
   logic [DW-1:0] deg_clamped;
   logic signed [XW-1:0] x_ff, y_ff;

   logic [bpe_pkg::COEF_COUNT-1:0] coef_vld_ff;

   // sequencer: row start, row, place in row
   logic [AW-1:0] row_ff;
   logic [DW-1:0] d_ff, j_ff;

   logic req_accept, load_accept, eval_accept, coef_wr;
   logic [AW-1:0] k_addr, src_addr;
   logic first, src_zero, use_y, is_last, hazard, issue;

   // pipeline: B (RAM data), C (monomial), T (term)
   logic          b_vld_ff, b_first_ff, b_src0_ff, b_use_y_ff, b_last_ff, b_cvld_ff;
   logic [AW-1:0] b_addr_ff;
   logic          c_vld_ff, c_last_ff;
   logic [AW-1:0] c_addr_ff;
   logic signed [MW-1:0] m_ff, m_in;
   logic signed [CW-1:0] coef_ff, coef_in;
   logic          t_vld_ff, t_last_ff;
   logic signed [ACW-1:0] term_ff;
   logic signed [ACW-1:0] acc_ff;

   logic signed [MW-1:0] mono_rd, mono_operand;
   logic [CW-1:0] coef_rd;

   logic rsp_valid_ff, rsp_load;
   bpe_pkg::rsp_word_type rsp_data_ff;
   logic fits;

   // configuration port
   assign pready = 1'b1;
   assign prdata = bpe_pkg::CSR_DATA_W'(poly_degree_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_degree_ff <= '0;
      end else if (psel && penable && pwrite
                   && paddr[bpe_pkg::CSR_ADDR_W-1:2] == bpe_pkg::REG_POLY_DEGREE) begin
         poly_degree_ff <= pwdata[DW-1:0];
      end
   end

   assign deg_clamped = (poly_degree_ff > DW'(bpe_pkg::EFF_MAX_DEGREE))
                      ? DW'(bpe_pkg::EFF_MAX_DEGREE) : poly_degree_ff;

   // input side
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign load_accept = req_accept && req_data.req_type == bpe_pkg::REQ_LOAD;
   assign eval_accept = req_accept && req_data.req_type == bpe_pkg::REQ_EVAL;
   assign coef_wr     = load_accept
                     && req_data.coef_index < bpe_pkg::INDEX_WIDTH'(bpe_pkg::COEF_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_wr) begin
         coef_vld_ff[req_data.coef_index[AW-1:0]] <= 1'b1;
      end
   end

   // term sequencing; entry j<d of row d comes from x * prev[j], the last from y * prev[d-1]
   assign k_addr   = row_ff + AW'(j_ff);
   assign use_y    = (j_ff == d_ff);
   assign src_addr = use_y ? (row_ff - AW'(1)) : (row_ff - AW'(d_ff) + AW'(j_ff));
   assign first    = (d_ff == '0);
   assign src_zero = (src_addr == '0);
   assign is_last  = (d_ff == deg_ff) && use_y;
   // source monomial still in flight: wait for its write-back
   assign hazard   = !first && !src_zero
                  && ((b_vld_ff && b_addr_ff == src_addr) || (c_vld_ff && c_addr_ff == src_addr));
   assign issue    = (state_ff == ST_RUN) && !hazard;

   always_ff @(posedge clock) begin
      if (eval_accept) begin
         row_ff <= '0;
         d_ff   <= '0;
         j_ff   <= '0;
         deg_ff <= deg_clamped;
         x_ff   <= req_data.pos_x;
         y_ff   <= req_data.pos_y;
      end else if (issue) begin
         if (use_y) begin
            row_ff <= row_ff + AW'(d_ff) + AW'(1);
            d_ff   <= d_ff + DW'(1);
            j_ff   <= '0;
         end else begin
            j_ff <= j_ff + DW'(1);
         end
      end
   end

   // memories
   bpe_ram #(.WIDTH(CW), .DEPTH(bpe_pkg::COEF_COUNT)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (req_data.coef_index[AW-1:0]),
      .wr_data (req_data.coef_value),
      .rd_addr (k_addr),
      .rd_data (coef_rd)
   );

   bpe_ram #(.WIDTH(MW), .DEPTH(bpe_pkg::COEF_COUNT)) u_mono_ram (
      .clock   (clock),
      .wr_en   (c_vld_ff),
      .wr_addr (c_addr_ff),
      .wr_data (m_ff),
      .rd_addr (src_addr),
      .rd_data (mono_rd)
   );

   // stage B: monomial product
   assign mono_operand = b_src0_ff ? bpe_pkg::MONO_ONE : mono_rd;
   assign m_in    = b_first_ff ? bpe_pkg::MONO_ONE
                  : bpe_pkg::mono_mul(b_use_y_ff ? y_ff : x_ff, mono_operand);
   assign coef_in = b_cvld_ff ? coef_rd : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         t_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= issue;
         c_vld_ff <= b_vld_ff;
         t_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_addr_ff  <= k_addr;
      b_first_ff <= first;
      b_src0_ff  <= src_zero;
      b_use_y_ff <= use_y;
      b_last_ff  <= is_last;
      b_cvld_ff  <= coef_vld_ff[k_addr];
      c_addr_ff  <= b_addr_ff;
      c_last_ff  <= b_last_ff;
      m_ff       <= m_in;
      coef_ff    <= coef_in;
      t_last_ff  <= c_last_ff;
      term_ff    <= bpe_pkg::term_mul(coef_ff, m_ff);
      if (eval_accept) begin
         acc_ff <= '0;
      end else if (t_vld_ff) begin
         acc_ff <= acc_ff + term_ff;
      end
   end

   // control
   assign rsp_load = (state_ff == ST_WRITE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (eval_accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (issue && is_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (t_vld_ff && t_last_ff) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   // output word, clipped to 32 bits
   assign fits = (acc_ff[ACW-1:OW-1] == {(ACW - OW + 1){acc_ff[OW-1]}});

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.saturated <= !fits;
         if (fits) begin
            rsp_data_ff.poly_value <= acc_ff[OW-1:0];
         end else if (acc_ff[ACW-1]) begin
            rsp_data_ff.poly_value <= {1'b1, {(OW - 1){1'b0}}};
         end else begin
            rsp_data_ff.poly_value <= {1'b0, {(OW - 1){1'b1}}};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
